@@ rtl/emd_pkg.sv @@
// Shared types and constants for the event message deframer.
// No dependencies; imported by every module of the block.
package emd_pkg;

  localparam logic [31:0] RESET_MAX_LENGTH = 32'd4194304;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC  = 2'd1;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

  localparam logic [3:0] POS_MAGIC0  = 4'd0;
  localparam logic [3:0] POS_LEN0    = 4'd4;
  localparam logic [3:0] POS_LEN3    = 4'd7;
  localparam logic [3:0] POS_PAYLOAD = 4'd8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } emd_item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h49;  // I
      2'd1:    b = 8'h4E;  // N
      2'd2:    b = 8'h45;  // E
      default: b = 8'h56;  // V
    endcase
    return b;
  endfunction

endpackage

@@ rtl/emd_front.sv @@
// Front end: accepts link bytes, tracks the header, classifies each byte.
// Pushes payload and error results into the queue. Depends on emd_pkg.
module emd_front import emd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output emd_item_t   push_item
);

  logic [3:0]  position, position_next;
  logic [31:0] length_value, length_value_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] length_limit;

  logic [3:0]  pos_eff;
  logic [31:0] len_full;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign pos_eff  = (position > POS_PAYLOAD) ? POS_MAGIC0 : position;
  assign len_full = length_value | ({24'b0, rx_byte} << {pos_eff[1:0], 3'b000});

  always_comb begin
    position_next        = position;
    length_value_next    = length_value;
    bytes_remaining_next = bytes_remaining;
    push                 = 1'b0;
    push_item            = '0;
    if (accept) begin
      if (pos_eff < POS_LEN0) begin
        if (rx_byte != magic_byte(pos_eff[1:0])) begin
          push                 = 1'b1;
          push_item.status     = STATUS_BAD_MAGIC;
          position_next        = POS_MAGIC0;
          length_value_next    = '0;
          bytes_remaining_next = '0;
        end else begin
          position_next = pos_eff + 4'd1;
        end
      end else if (pos_eff < POS_PAYLOAD) begin
        if (pos_eff != POS_LEN3) begin
          length_value_next = len_full;
          position_next     = pos_eff + 4'd1;
        end else if (len_full == '0 || len_full > length_limit) begin
          push                 = 1'b1;
          push_item.status     = STATUS_BAD_LENGTH;
          position_next        = POS_MAGIC0;
          length_value_next    = '0;
          bytes_remaining_next = '0;
        end else begin
          length_value_next    = len_full;
          bytes_remaining_next = len_full;
          position_next        = POS_PAYLOAD;
        end
      end else begin
        push             = 1'b1;
        push_item.data   = rx_byte;
        push_item.status = STATUS_OK;
        push_item.last   = (bytes_remaining[31:1] == '0);
        if (bytes_remaining[31:1] == '0) begin
          position_next        = POS_MAGIC0;
          length_value_next    = '0;
          bytes_remaining_next = '0;
        end else begin
          bytes_remaining_next = bytes_remaining - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= POS_MAGIC0;
      length_value    <= '0;
      bytes_remaining <= '0;
      length_limit    <= RESET_MAX_LENGTH;
    end else begin
      position        <= position_next;
      length_value    <= length_value_next;
      bytes_remaining <= bytes_remaining_next;
      if (cfg_we) begin
        length_limit <= cfg_data;
      end
    end
  end

endmodule

@@ rtl/emd_queue.sv @@
// Short FIFO of classified results between front and back.
// Depends on emd_pkg for the item type.
module emd_queue import emd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  emd_item_t push_item,
  input  logic      pop,
  output emd_item_t pop_item,
  output logic      empty,
  output logic      full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  emd_item_t         slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign empty    = (count == '0);
  assign full     = (count == FULL_COUNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/emd_back.sv @@
// Back end: drains the queue into the output register, keeps message count.
// Depends on emd_pkg.
module emd_back import emd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  emd_item_t   q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [1:0]  status,
  output logic [31:0] events_received
);

  logic [31:0] message_count;

  assign pop             = !q_empty && (!out_valid || out_ready);
  assign events_received = message_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      message_count <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (q_item.last && q_item.status == STATUS_OK) begin
        message_count <= message_count + 32'd1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte  <= q_item.data;
      last_byte <= q_item.last;
      status    <= q_item.status;
    end
  end

endmodule

@@ rtl/event_message_deframer.sv @@
// Event message deframer, top level: front parser, result queue, back end.
// Depends on emd_pkg, emd_front, emd_queue, emd_back.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries link bytes. Each message
//   is the magic 'INEV', a 32-bit little-endian length, then the payload.
//   Output channel (out_valid/out_ready) carries one request per payload byte
//   (status ok, last_byte on the final one) or one error request per bad
//   magic byte or bad length; the parser then waits for a fresh header.
//   events_received is the completed message count including this request.
//   max_length_we/max_length write the length limit; write only when idle.
// Timing:
//   One byte accepted per cycle while in_ready is high. Valid header bytes
//   give no request. Requests pass through the queue to the output register.
//   The front and back are split by a QUEUE_DEPTH_P entry queue; when the
//   receiver stalls the queue fills and in_ready drops once it is full.
// Reset:
//   rst clears the parser, the queue, the output valid flag and the message
//   count, and sets max_length to 4194304.
module event_message_deframer import emd_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        max_length_we,
  input  logic [31:0] max_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [1:0]  status,
  output logic [31:0] events_received
);

  logic      push;
  emd_item_t push_item;
  logic      pop;
  emd_item_t pop_item;
  logic      q_empty;
  logic      q_full;

  emd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_we    (max_length_we),
    .cfg_data  (max_length),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  emd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  emd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .status          (status),
    .events_received (events_received)
  );

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> out_byte == 8'd0 && !last_byte)
    else $error("error request carries payload bits");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !pop)
    else $error("queue drained while output stalled");

  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    events_received != $past(events_received) |->
      out_valid && last_byte && status == STATUS_OK)
    else $error("message count moved without a final payload byte");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("front pushed into a full queue");

endmodule

@@ tb/event_message_deframer_tb.sv @@
// Self-checking testbench for event_message_deframer: drives link bytes and checks every
// output request against a built-in model of the INEV magic/length deframer.
// Depends on emd_pkg and the event_message_deframer RTL.
module event_message_deframer_tb;
  import emd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MAGIC_WORD = {8'h56, 8'h45, 8'h4E, 8'h49};  // V E N I
  localparam int TAIL_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [31:0] count;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        max_length_we = 1'b0;
  logic [31:0] max_length = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic [1:0]  status;
  logic [31:0] events_received;

  // model state
  logic [3:0]  hdr_pos = POS_MAGIC0;
  logic [31:0] len_acc = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] msg_count = '0;
  logic [31:0] max_len_cfg = RESET_MAX_LENGTH;

  deframed_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int n_payload = 0;
  int n_messages = 0;
  int n_bad_magic = 0;
  int n_bad_length = 0;
  int idle_cycles = 0;

  event_message_deframer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .max_length_we(max_length_we),
    .max_length(max_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .last_byte(last_byte),
    .status(status),
    .events_received(events_received)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] magic_at(input int k);
    return MAGIC_WORD[8*k +: 8];
  endfunction

  function automatic void restart_frame();
    hdr_pos = POS_MAGIC0;
    len_acc = '0;
    bytes_left = '0;
  endfunction

  // Advance the deframer model by one accepted byte; queue the request it yields.
  function automatic void deframe_byte(input logic [7:0] b);
    deframed_t r;
    logic [3:0] pos;
    logic       emit;
    r = '0;
    emit = 1'b0;
    pos = (hdr_pos > POS_PAYLOAD) ? POS_MAGIC0 : hdr_pos;
    if (pos < POS_LEN0) begin
      if (b != magic_at(pos[1:0])) begin
        r.status = STATUS_BAD_MAGIC;
        emit = 1'b1;
        restart_frame();
      end else begin
        hdr_pos = pos + 4'd1;
      end
    end else if (pos <= POS_LEN3) begin
      len_acc = len_acc | (32'(b) << {pos[1:0], 3'b000});
      if (pos < POS_LEN3) begin
        hdr_pos = pos + 4'd1;
      end else if (len_acc == 0 || len_acc > max_len_cfg) begin
        r.status = STATUS_BAD_LENGTH;
        emit = 1'b1;
        restart_frame();
      end else begin
        bytes_left = len_acc;
        hdr_pos = POS_PAYLOAD;
      end
    end else begin
      r.data = b;
      r.status = STATUS_OK;
      r.last = (bytes_left <= 1);
      emit = 1'b1;
      if (r.last) begin
        msg_count = msg_count + 1;
        restart_frame();
      end else begin
        bytes_left = bytes_left - 1;
      end
    end
    r.count = msg_count;
    if (emit) pending_results = {pending_results, r};
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deframed_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected request, expected none, got byte %0h last %0b status %0d",
                 $time, out_byte, last_byte, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", 32'(want.data), 32'(out_byte));
        check_field("last_byte", 32'(want.last), 32'(last_byte));
        check_field("status", 32'(want.status), 32'(status));
        check_field("events_received", want.count, events_received);
      end
      case (status)
        STATUS_BAD_MAGIC:  n_bad_magic++;
        STATUS_BAD_LENGTH: n_bad_length++;
        default: begin
          n_payload++;
          if (last_byte) n_messages++;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d requests outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [31:0] v);
    wait_drained();
    @(negedge clk);
    max_length_we <= 1'b1;
    max_length <= v;
    @(negedge clk);
    max_length_we <= 1'b0;
    max_len_cfg = v;
  endtask

  task automatic send_magic_prefix(input int k);
    for (int i = 0; i < k; i++) send_byte(magic_at(i));
  endtask

  task automatic send_header(input logic [31:0] len);
    send_magic_prefix(4);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_message(input int len);
    send_header(len);
    repeat (len) send_byte(8'($urandom));
  endtask

  // Wrong byte at a random point of the magic; the byte is forced off the expected value.
  task automatic send_broken_magic();
    int k;
    logic [7:0] b;
    k = $urandom_range(3);
    b = 8'($urandom);
    if (b == magic_at(k)) b ^= 8'h80;
    send_magic_prefix(k);
    send_byte(b);
  endtask

  function automatic int pick_len();
    int lim;
    lim = (max_len_cfg < 40) ? int'(max_len_cfg) : 40;
    if ($urandom_range(9) == 0) return $urandom_range(lim, 1);
    return $urandom_range((lim < 6) ? lim : 6, 1);
  endfunction

  function automatic logic [31:0] pick_bad_len();
    logic [31:0] span;
    if (max_len_cfg == 32'hFFFF_FFFF || $urandom_range(3) == 0) return 32'h0;
    span = 32'hFFFF_FFFF - max_len_cfg;
    case ($urandom_range(2))
      0:       return max_len_cfg + 1;
      1:       return 32'hFFFF_FFFF;
      default: return max_len_cfg + 1 + ($urandom % span);
    endcase
  endfunction

  task automatic test_directed_frames();
    send_header(32'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_magic_prefix(3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(32'd0);
  endtask

  task automatic test_length_limits();
    set_max_length(32'd1);
    send_message(1);
    send_header(32'd2);
    set_max_length(32'd0);
    send_header(32'd1);
    set_max_length(32'hFFFF_FFFF);
    send_message(3);
    set_max_length(RESET_MAX_LENGTH);
    send_message(2);
    send_header(RESET_MAX_LENGTH + 1);
    send_header(32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                     input int stall_pct, input int pause_at);
    int stop_at;
    int pick;
    logic paused;
    stop_at = bytes_sent + n_bytes;
    paused = (pause_at == 0);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) send_message(pick_len());
      else if (pick < 85) send_broken_magic();
      else send_header(pick_bad_len());
      if (!paused && bytes_sent >= stop_at - n_bytes + pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_length_limits();
    test_random_traffic(225, 0, 0, 0);
    set_max_length(32'd16);
    test_random_traffic(225, 80, 0, 110);
    set_max_length(32'hFFFF_FFFF);
    test_random_traffic(225, 0, 80, 0);
    set_max_length(32'd3);
    test_random_traffic(225, 30, 30, 0);
    wait_drained();
    $display("Sent %0d link bytes under limits 0..2^32-1 and four pacing phases;", bytes_sent);
    $display("checked %0d payload requests (%0d messages), %0d bad magic, %0d bad length.",
             n_payload, n_messages, n_bad_magic, n_bad_length);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ event_message_deframer.f @@
rtl/emd_pkg.sv
rtl/emd_front.sv
rtl/emd_queue.sv
rtl/emd_back.sv
rtl/event_message_deframer.sv
tb/event_message_deframer_tb.sv
